### hdl/plr_pkg.sv
// shared types and constants of the page replacement block
// no dependencies; used by the interfaces, the frame store and the top level
package plr_pkg;

  localparam int FRAMES_DEF   = 16;
  localparam int TAG_BITS_DEF = 32;

  // fixed field widths of the channels
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 32;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 4'd1;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  // lookup outcome of one item, from the frame store to the top level
  typedef struct packed {
    logic             hit;
    logic             evict;
    logic [TAG_W-1:0] evict_tag;
  } plr_result_t;

endpackage

### hdl/plr_if.sv
// valid/ready channel interfaces: page access input, result output, config write
// depends on plr_pkg for the field widths
interface plr_in_if;
  logic                     valid;
  logic                     ready;
  logic [plr_pkg::TAG_W-1:0] page_tag;

  modport source (output valid, output page_tag, input ready);
  modport sink (input valid, input page_tag, output ready);
endinterface

interface plr_out_if;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic                     evicted_valid;
  logic [plr_pkg::TAG_W-1:0] evicted_tag;
  logic [plr_pkg::CNT_W-1:0] fault_total;
  logic [plr_pkg::CNT_W-1:0] access_total;

  modport source (output valid, output hit, output evicted_valid, output evicted_tag,
                  output fault_total, output access_total, input ready);
  modport sink (input valid, input hit, input evicted_valid, input evicted_tag,
                input fault_total, input access_total, output ready);
endinterface

interface plr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [plr_pkg::CFG_IDX_W-1:0]  index;
  logic [plr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/page_replacement_lru_fifo_top.sv
// top level of the fully associative page replacement block
// depends on plr_pkg, plr_if and plr_frames
//
// One page access per clock cycle, sustained while out_o.ready stays high. An
// accepted item waits in the input register until the output register can take
// it; then all frame tags are compared in parallel, the order ranks, occupancy
// and counters are updated, and the result is loaded into the output register,
// from which it can leave. The combinational tag compare and rank update of the
// frame store set the rate: each item sees the state left by the one before.
// The input side keeps accepting while a result waits, until both registers
// are full. Reset empties the frame store at once (ranks and occupancy are
// flip-flops), so there is no clearing pass. Configuration writes are always
// ready; frame_limit 0 acts as 1 and values above FRAMES act as FRAMES.
module page_replacement_lru_fifo_top #(
  parameter int FRAMES   = plr_pkg::FRAMES_DEF,
  parameter int TAG_BITS = plr_pkg::TAG_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plr_in_if.sink     in_i,
  plr_out_if.source  out_o,
  plr_cfg_if.sink    cfg_i
);

  localparam int OCC_W = $clog2(FRAMES + 1);

  logic [plr_pkg::LIMIT_W-1:0] frame_limit_q;
  logic                        policy_q;
  logic [OCC_W-1:0]            limit_eff;

  logic                in_valid_q;
  logic [TAG_BITS-1:0] in_tag_q;
  logic                fire;

  plr_pkg::plr_result_t      res;
  logic [plr_pkg::CNT_W-1:0] fault_q, fault_d;
  logic [plr_pkg::CNT_W-1:0] access_q, access_d;

  logic                      out_valid_q;
  logic                      hit_q, evict_q;
  logic [plr_pkg::TAG_W-1:0] evict_tag_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= plr_pkg::LIMIT_RESET;
      policy_q      <= plr_pkg::POLICY_LRU;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        plr_pkg::CFG_FRAME_LIMIT: frame_limit_q <= cfg_i.data[plr_pkg::LIMIT_W-1:0];
        plr_pkg::CFG_POLICY_MODE: policy_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_limit_q == '0) begin
      limit_eff = OCC_W'(1);
    end else if (int'(frame_limit_q) > FRAMES) begin
      limit_eff = OCC_W'(FRAMES);
    end else begin
      limit_eff = OCC_W'(frame_limit_q);
    end
  end

  // input register, drains into the result register
  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_tag_q <= TAG_BITS'(in_i.page_tag);
    end
  end

  plr_frames #(
    .FRAMES   (FRAMES),
    .TAG_BITS (TAG_BITS)
  ) u_frames (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .tag_i    (in_tag_q),
    .policy_i (policy_q),
    .limit_i  (limit_eff),
    .result_o (res)
  );

  // saturating counters
  assign access_d = (access_q == plr_pkg::CNT_MAX) ? access_q
                                                   : access_q + plr_pkg::CNT_W'(1);
  assign fault_d  = (res.hit || (fault_q == plr_pkg::CNT_MAX)) ? fault_q
                                                               : fault_q + plr_pkg::CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_q    <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        access_q <= access_d;
        fault_q  <= fault_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q       <= res.hit;
      evict_q     <= res.evict;
      evict_tag_q <= res.evict_tag;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = hit_q;
  assign out_o.evicted_valid = evict_q;
  assign out_o.evicted_tag   = evict_tag_q;
  assign out_o.fault_total   = fault_q;
  assign out_o.access_total  = access_q;

  a_fault_le_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fault_q <= access_q))
    else $error("fault total above access total");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result register empty after an item moved in");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(in_tag_q)))
    else $error("waiting item lost from the input register");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> !(hit_q && evict_q))
    else $error("eviction reported on a hit");

endmodule

### hdl/plr_frames.sv
// frame store: tags, order ranks and occupancy, with combinational parallel tag
// compare, victim select and rank update; depends on plr_pkg
module plr_frames #(
  parameter int FRAMES   = plr_pkg::FRAMES_DEF,
  parameter int TAG_BITS = plr_pkg::TAG_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [TAG_BITS-1:0]               tag_i,
  input  logic                              policy_i,
  input  logic [$clog2(FRAMES+1)-1:0]       limit_i,
  output plr_pkg::plr_result_t              result_o
);

  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int AGE_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [TAG_BITS-1:0] tags_q [FRAMES];
  logic [AGE_W-1:0]    age_q  [FRAMES];
  logic [AGE_W-1:0]    age_d  [FRAMES];
  logic [OCC_W-1:0]    occ_q, occ_d;

  logic [FRAMES-1:0] occupied;
  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] tag_we;
  logic [AGE_W-1:0]  hit_idx, victim_idx, prom_idx;
  logic [AGE_W-1:0]  prom_rank, newest;
  logic              hit, full, prom_en, fill;

  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    // scan downward so the lowest matching frame wins
    for (int i = FRAMES - 1; i >= 0; i--) begin
      occupied[i] = OCC_W'(i) < occ_q;
      match[i]    = occupied[i] && (tags_q[i] == tag_i);
      if (match[i]) begin
        hit_idx = AGE_W'(i);
      end
      if (occupied[i] && (age_q[i] == '0)) begin
        victim_idx = AGE_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign full      = occ_q >= limit_i;
  assign fill      = !hit && !full;
  assign prom_en   = (hit && (policy_i == plr_pkg::POLICY_LRU)) || (!hit && full);
  assign prom_idx  = hit ? hit_idx : victim_idx;
  assign prom_rank = age_q[prom_idx];
  assign newest    = AGE_W'(occ_q - OCC_W'(1));

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      age_d[i]  = age_q[i];
      tag_we[i] = 1'b0;
      if (prom_en && occupied[i] && (age_q[i] > prom_rank)) begin
        age_d[i] = age_q[i] - AGE_W'(1);
      end
      if (prom_en && (AGE_W'(i) == prom_idx)) begin
        age_d[i]  = newest;
        tag_we[i] = !hit;
      end
      if (fill && (OCC_W'(i) == occ_q)) begin
        age_d[i]  = AGE_W'(occ_q);
        tag_we[i] = 1'b1;
      end
    end
  end

  assign occ_d = fill ? occ_q + OCC_W'(1) : occ_q;

  assign result_o.hit       = hit;
  assign result_o.evict     = !hit && full;
  assign result_o.evict_tag = (!hit && full) ? plr_pkg::TAG_W'(tags_q[victim_idx]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        age_q[i] <= '0;
      end
    end else if (fire_i) begin
      occ_q <= occ_d;
      for (int i = 0; i < FRAMES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  // tags are undefined until written, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAMES; i++) begin
      if (fire_i && tag_we[i]) begin
        tags_q[i] <= tag_i;
      end
    end
  end

endmodule
